@@ design/pn2d_pkg.sv @@
// Shared constants and types for the 2D gradient noise core.
// Depends on nothing; every other file of the core uses it.
`timescale 1ns / 1ps

package pn2d_pkg;

   // Table geometry.
   localparam int TABLE_SIZE = 256;
   localparam int IDX_W      = $clog2(TABLE_SIZE);
   localparam int BYTE_W     = 8;

   // Coordinate format: unsigned fixed point with FRAC_BITS fraction bits.
   localparam int FRAC_BITS  = 16;
   localparam int COORD_W    = 24;

   // Derived datapath widths.
   localparam int FADE_W     = FRAC_BITS + 1;   // fade value, 0 .. 1.0
   localparam int CORNER_W   = FRAC_BITS + 2;   // signed corner offset
   localparam int GRAD_W     = FRAC_BITS + 3;   // signed gradient dot product
   localparam int LERP_W     = FRAC_BITS + 5;   // signed blend result
   localparam int OUT_W      = 16;

   // Cycles from an accepted evaluate request to its result strobe.
   localparam int LATENCY    = 9;

   // Request operation codes.
   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_EVAL  = 1'b1;

   typedef logic [FRAC_BITS-1:0] frac_type;
   typedef logic [FADE_W-1:0]    fade_type;
   typedef logic [IDX_W-1:0]     idx_type;
   typedef logic [BYTE_W-1:0]    byte_type;

endpackage

@@ design/pn2d_fade.sv @@
// Four-stage pipelined quintic fade 6t^5 - 15t^4 + 10t^3 in fixed point.
// Depends on pn2d_pkg for the fraction and fade widths.
`timescale 1ns / 1ps

module pn2d_fade (
   input  logic                 clock,
   input  pn2d_pkg::frac_type   t_in,
   output pn2d_pkg::fade_type   fade_out
);

   localparam int F    = pn2d_pkg::FRAC_BITS;
   localparam int QW   = F + 4;
   localparam int Q2W  = 2 * F + 5;
   localparam logic [2*F:0] HALF_W = (2 * F + 1)'(1) << (F - 1);
   localparam logic [Q2W-1:0] HALF_Q = Q2W'(1) << (F - 1);
   localparam logic [Q2W-1:0] TEN_Q = Q2W'(10) << (2 * F);

   // Stage 1 registers.
   logic [F-1:0]    f1_t_ff;
   logic [2*F-1:0]  f1_tt_ff;
   // Stage 2 registers.
   logic [F-1:0]    f2_t_ff;
   logic [F-1:0]    f2_t2_ff;
   logic [QW-1:0]   f2_q_ff;
   // Stage 3 registers.
   logic [F-1:0]    f3_t3_ff;
   logic [QW-1:0]   f3_q_ff;
   // Stage 4 register.
   logic [pn2d_pkg::FADE_W-1:0] f4_fade_ff;

   logic [2*F:0]    t2_sum;
   logic [Q2W-1:0]  q2_sum;
   logic [Q2W-1:0]  q_round;
   logic [2*F:0]    t3_sum;
   logic [2*F+4:0]  fade_sum;

   // The square of the fraction, kept exact.
   always_ff @(posedge clock) begin
      f1_t_ff  <= t_in;
      f1_tt_ff <= (2 * F)'(t_in) * (2 * F)'(t_in);
   end

   // Rounded square, and the quadratic 6t^2 - 15t + 10 from the exact square.
   always_comb begin
      t2_sum  = {1'b0, f1_tt_ff} + HALF_W;
      q2_sum  = TEN_Q + Q2W'(f1_tt_ff) * Q2W'(6)
                - (Q2W'(f1_t_ff) << F) * Q2W'(15);
      q_round = q2_sum + HALF_Q;
   end

   always_ff @(posedge clock) begin
      f2_t_ff  <= f1_t_ff;
      f2_t2_ff <= t2_sum[F +: F];
      f2_q_ff  <= q_round[F +: QW];
   end

   // Cube of the fraction, with the full product width kept before rounding.
   assign t3_sum = (2 * F + 1)'(f2_t2_ff) * (2 * F + 1)'(f2_t_ff) + HALF_W;

   always_ff @(posedge clock) begin
      f3_t3_ff <= t3_sum[F +: F];
      f3_q_ff  <= f2_q_ff;
   end

   // Final product t^3 * q.
   assign fade_sum = (2 * F + 5)'(f3_t3_ff) * (2 * F + 5)'(f3_q_ff)
                     + ((2 * F + 5)'(1) << (F - 1));

   always_ff @(posedge clock) begin
      f4_fade_ff <= fade_sum[F +: pn2d_pkg::FADE_W];
   end

   assign fade_out = f4_fade_ff;

endmodule

@@ design/perlin_noise_2d_core.sv @@
// Top level of the 2D improved gradient noise core: request decode,
// permutation table copies, hashing, gradients and the bilinear blend.
// Depends on pn2d_pkg and pn2d_fade.
//
// Usage:
// - A request is taken at a rising edge with start high and busy low.
//   req_operation selects a table write (req_table_index, req_table_value)
//   or an evaluation at (req_x_coord, req_y_coord), both unsigned Q8.16.
// - A table write gives no result. An evaluation gives one result on
//   rsp_noise_value, marked by rsp_strobe for exactly one cycle.
// - Throughput is one request per clock while busy is low, writes and
//   evaluations mixed in any order. A result follows its request through
//   five register stages of capture, table lookups and gradients, which match
//   the capture register plus the four-stage fade unit, then four stages of
//   blending and output scaling.
// - Each lookup level reads its own copies of the permutation table; a table
//   write walks down the pipeline and updates each copy at the stage that
//   reads it, so every request sees the table in request order.
// - After reset busy stays high while the table copies are filled with
//   the identity permutation. No request is taken then.
// - The receiver cannot stall; each result must be taken when strobed.
`timescale 1ns / 1ps

module perlin_noise_2d_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic        req_operation,
   input  logic [7:0]  req_table_index,
   input  logic [7:0]  req_table_value,
   input  logic [23:0] req_x_coord,
   input  logic [23:0] req_y_coord,
   output logic        rsp_strobe,
   output logic [15:0] rsp_noise_value
);

   localparam int F   = pn2d_pkg::FRAC_BITS;
   localparam int IW  = pn2d_pkg::IDX_W;
   localparam int CW  = pn2d_pkg::CORNER_W;
   localparam int GW  = pn2d_pkg::GRAD_W;
   localparam int LW  = pn2d_pkg::LERP_W;
   localparam int P1W = CW + GW + 1;
   localparam int P2W = CW + LW;
   localparam int SW  = LW + 20;
   localparam logic signed [CW-1:0] ONE_C = CW'(1) << F;

   // Gradient dot product for one hashed corner.
   function automatic logic signed [GW-1:0] grad(
      input logic [7:0]             hash,
      input logic signed [CW-1:0]   gx,
      input logic signed [CW-1:0]   gy
   );
      logic [3:0]             h;
      logic signed [GW-1:0]   u;
      logic signed [GW-1:0]   v;
      h = hash[3:0];
      u = (h < 4'd8) ? GW'(gx) : GW'(gy);
      if (h < 4'd4) begin
         v = GW'(gy);
      end else if (h == 4'd12 || h == 4'd14) begin
         v = GW'(gx);
      end else begin
         v = '0;
      end
      return (h[0] ? -u : u) + (h[1] ? -v : v);
   endfunction

   // ---------------------------------------------------------------
   // Table fill after reset.
   logic                  init_busy_ff;
   pn2d_pkg::idx_type     init_cnt_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         init_busy_ff <= 1'b1;
         init_cnt_ff  <= '0;
      end else if (init_busy_ff) begin
         init_cnt_ff <= init_cnt_ff + IW'(1);
         if (init_cnt_ff == IW'(pn2d_pkg::TABLE_SIZE - 1)) begin
            init_busy_ff <= 1'b0;
         end
      end
   end

   assign busy = init_busy_ff;

   logic accept;
   assign accept = start && !init_busy_ff;

   // ---------------------------------------------------------------
   // Stage 1: request capture and first table level.
   logic                  s1_valid_ff;
   logic                  s1_op_ff;
   pn2d_pkg::idx_type     s1_idx_ff;
   pn2d_pkg::byte_type    s1_val_ff;
   logic [23:0]           s1_x_ff;
   logic [23:0]           s1_y_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      s1_op_ff  <= req_operation;
      s1_idx_ff <= req_table_index[IW-1:0];
      s1_val_ff <= req_table_value;
      s1_x_ff   <= req_x_coord;
      s1_y_ff   <= req_y_coord;
   end

   // Level 1 table copy: reads the two x corners.
   pn2d_pkg::byte_type    perm_l1_mem [pn2d_pkg::TABLE_SIZE];
   pn2d_pkg::byte_type    pa_ff;
   pn2d_pkg::byte_type    pb_ff;
   logic                  l1_we_in;
   pn2d_pkg::idx_type     l1_wa_in;
   pn2d_pkg::byte_type    l1_wd_in;
   pn2d_pkg::idx_type     cx;

   always_comb begin
      cx       = req_x_coord[F +: IW];
      l1_we_in = init_busy_ff || (accept && req_operation == pn2d_pkg::OP_WRITE);
      l1_wa_in = init_busy_ff ? init_cnt_ff : req_table_index[IW-1:0];
      l1_wd_in = init_busy_ff ? 8'(init_cnt_ff) : req_table_value;
   end

   always_ff @(posedge clock) begin
      if (l1_we_in) begin
         perm_l1_mem[l1_wa_in] <= l1_wd_in;
      end
      pa_ff <= perm_l1_mem[cx];
      pb_ff <= perm_l1_mem[cx + IW'(1)];
   end

   // ---------------------------------------------------------------
   // Stage 2: second table level, fraction carry.
   logic                  s2_valid_ff;
   logic                  s2_op_ff;
   pn2d_pkg::idx_type     s2_idx_ff;
   pn2d_pkg::byte_type    s2_val_ff;
   pn2d_pkg::frac_type    s2_fx_ff;
   pn2d_pkg::frac_type    s2_fy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      s2_op_ff  <= s1_op_ff;
      s2_idx_ff <= s1_idx_ff;
      s2_val_ff <= s1_val_ff;
      s2_fx_ff  <= s1_x_ff[F-1:0];
      s2_fy_ff  <= s1_y_ff[F-1:0];
   end

   // Level 2 table copies, one for each x corner.
   pn2d_pkg::byte_type    perm_l2a_mem [pn2d_pkg::TABLE_SIZE];
   pn2d_pkg::byte_type    perm_l2b_mem [pn2d_pkg::TABLE_SIZE];
   pn2d_pkg::byte_type    aa_ff;
   pn2d_pkg::byte_type    ab_ff;
   pn2d_pkg::byte_type    ba_ff;
   pn2d_pkg::byte_type    bb_ff;
   logic                  l2_we_in;
   pn2d_pkg::idx_type     l2_wa_in;
   pn2d_pkg::byte_type    l2_wd_in;
   pn2d_pkg::idx_type     cy;
   pn2d_pkg::idx_type     ra_lo;
   pn2d_pkg::idx_type     rb_lo;

   always_comb begin
      cy       = s1_y_ff[F +: IW];
      ra_lo    = IW'(pa_ff) + cy;
      rb_lo    = IW'(pb_ff) + cy;
      l2_we_in = init_busy_ff || (s1_valid_ff && s1_op_ff == pn2d_pkg::OP_WRITE);
      l2_wa_in = init_busy_ff ? init_cnt_ff : s1_idx_ff;
      l2_wd_in = init_busy_ff ? 8'(init_cnt_ff) : s1_val_ff;
   end

   always_ff @(posedge clock) begin
      if (l2_we_in) begin
         perm_l2a_mem[l2_wa_in] <= l2_wd_in;
         perm_l2b_mem[l2_wa_in] <= l2_wd_in;
      end
      aa_ff <= perm_l2a_mem[ra_lo];
      ab_ff <= perm_l2a_mem[ra_lo + IW'(1)];
      ba_ff <= perm_l2b_mem[rb_lo];
      bb_ff <= perm_l2b_mem[rb_lo + IW'(1)];
   end

   // Fade units for both fractions; their output lines up with stage 5.
   pn2d_pkg::fade_type    fade_u;
   pn2d_pkg::fade_type    fade_v;

   pn2d_fade u_fade_x (
      .clock    (clock),
      .t_in     (s1_x_ff[F-1:0]),
      .fade_out (fade_u)
   );

   pn2d_fade u_fade_y (
      .clock    (clock),
      .t_in     (s1_y_ff[F-1:0]),
      .fade_out (fade_v)
   );

   // ---------------------------------------------------------------
   // Stage 3: corner hashes. Writes leave the pipeline here.
   logic                  s3_valid_ff;
   pn2d_pkg::frac_type    s3_fx_ff;
   pn2d_pkg::frac_type    s3_fy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else begin
         s3_valid_ff <= s2_valid_ff && s2_op_ff == pn2d_pkg::OP_EVAL;
      end
   end

   always_ff @(posedge clock) begin
      s3_fx_ff <= s2_fx_ff;
      s3_fy_ff <= s2_fy_ff;
   end

   // Level 3 table copies.
   pn2d_pkg::byte_type    perm_l3a_mem [pn2d_pkg::TABLE_SIZE];
   pn2d_pkg::byte_type    perm_l3b_mem [pn2d_pkg::TABLE_SIZE];
   pn2d_pkg::byte_type    h00_ff;
   pn2d_pkg::byte_type    h01_ff;
   pn2d_pkg::byte_type    h10_ff;
   pn2d_pkg::byte_type    h11_ff;
   logic                  l3_we_in;
   pn2d_pkg::idx_type     l3_wa_in;
   pn2d_pkg::byte_type    l3_wd_in;

   always_comb begin
      l3_we_in = init_busy_ff || (s2_valid_ff && s2_op_ff == pn2d_pkg::OP_WRITE);
      l3_wa_in = init_busy_ff ? init_cnt_ff : s2_idx_ff;
      l3_wd_in = init_busy_ff ? 8'(init_cnt_ff) : s2_val_ff;
   end

   always_ff @(posedge clock) begin
      if (l3_we_in) begin
         perm_l3a_mem[l3_wa_in] <= l3_wd_in;
         perm_l3b_mem[l3_wa_in] <= l3_wd_in;
      end
      h00_ff <= perm_l3a_mem[IW'(aa_ff)];
      h01_ff <= perm_l3a_mem[IW'(ab_ff)];
      h10_ff <= perm_l3b_mem[IW'(ba_ff)];
      h11_ff <= perm_l3b_mem[IW'(bb_ff)];
   end

   // ---------------------------------------------------------------
   // Stage 4: corner gradients.
   logic                   s4_valid_ff;
   logic signed [GW-1:0]   s4_g00_ff;
   logic signed [GW-1:0]   s4_g10_ff;
   logic signed [GW-1:0]   s4_g01_ff;
   logic signed [GW-1:0]   s4_g11_ff;
   logic signed [CW-1:0]   x0;
   logic signed [CW-1:0]   y0;
   logic signed [CW-1:0]   x1;
   logic signed [CW-1:0]   y1;

   always_comb begin
      x0 = $signed(CW'(s3_fx_ff));
      y0 = $signed(CW'(s3_fy_ff));
      x1 = x0 - ONE_C;
      y1 = y0 - ONE_C;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_valid_ff <= 1'b0;
      end else begin
         s4_valid_ff <= s3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      s4_g00_ff <= grad(h00_ff, x0, y0);
      s4_g10_ff <= grad(h10_ff, x1, y0);
      s4_g01_ff <= grad(h01_ff, x0, y1);
      s4_g11_ff <= grad(h11_ff, x1, y1);
   end

   // Stage 5: gradients wait for the fade values.
   logic                   s5_valid_ff;
   logic signed [GW-1:0]   s5_g00_ff;
   logic signed [GW-1:0]   s5_g10_ff;
   logic signed [GW-1:0]   s5_g01_ff;
   logic signed [GW-1:0]   s5_g11_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s5_valid_ff <= 1'b0;
      end else begin
         s5_valid_ff <= s4_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      s5_g00_ff <= s4_g00_ff;
      s5_g10_ff <= s4_g10_ff;
      s5_g01_ff <= s4_g01_ff;
      s5_g11_ff <= s4_g11_ff;
   end

   // ---------------------------------------------------------------
   // Stage 6: x blend products.
   logic                   s6_valid_ff;
   logic signed [P1W-1:0]  s6_p0_ff;
   logic signed [P1W-1:0]  s6_p1_ff;
   logic signed [GW-1:0]   s6_a0_ff;
   logic signed [GW-1:0]   s6_a1_ff;
   pn2d_pkg::fade_type     s6_v_ff;
   logic signed [CW-1:0]   u_s;
   logic signed [GW:0]     d0;
   logic signed [GW:0]     d1;

   always_comb begin
      u_s = $signed(CW'(fade_u));
      d0  = (GW + 1)'(s5_g10_ff) - (GW + 1)'(s5_g00_ff);
      d1  = (GW + 1)'(s5_g11_ff) - (GW + 1)'(s5_g01_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s6_valid_ff <= 1'b0;
      end else begin
         s6_valid_ff <= s5_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      s6_p0_ff <= P1W'(u_s) * P1W'(d0);
      s6_p1_ff <= P1W'(u_s) * P1W'(d1);
      s6_a0_ff <= s5_g00_ff;
      s6_a1_ff <= s5_g01_ff;
      s6_v_ff  <= fade_v;
   end

   // Stage 7: x blend sums and the y difference.
   logic                   s7_valid_ff;
   logic signed [LW-1:0]   s7_l0_ff;
   logic signed [LW-1:0]   s7_d_ff;
   pn2d_pkg::fade_type     s7_v_ff;
   logic signed [P1W-1:0]  r0;
   logic signed [P1W-1:0]  r1;
   logic signed [LW-1:0]   l0;
   logic signed [LW-1:0]   l1;

   always_comb begin
      r0 = (s6_p0_ff + P1W'(1 << (F - 1))) >>> F;
      r1 = (s6_p1_ff + P1W'(1 << (F - 1))) >>> F;
      l0 = LW'(s6_a0_ff) + r0[LW-1:0];
      l1 = LW'(s6_a1_ff) + r1[LW-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s7_valid_ff <= 1'b0;
      end else begin
         s7_valid_ff <= s6_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      s7_l0_ff <= l0;
      s7_d_ff  <= l1 - l0;
      s7_v_ff  <= s6_v_ff;
   end

   // Stage 8: y blend product.
   logic                   s8_valid_ff;
   logic signed [P2W-1:0]  s8_p_ff;
   logic signed [LW-1:0]   s8_l0_ff;
   logic signed [CW-1:0]   v_s;

   assign v_s = $signed(CW'(s7_v_ff));

   always_ff @(posedge clock) begin
      if (reset) begin
         s8_valid_ff <= 1'b0;
      end else begin
         s8_valid_ff <= s7_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      s8_p_ff  <= P2W'(v_s) * P2W'(s7_d_ff);
      s8_l0_ff <= s7_l0_ff;
   end

   // ---------------------------------------------------------------
   // Stage 9: final sum, map to [0,1] in Q0.16 and saturate.
   logic                   rsp_strobe_ff;
   logic [15:0]            rsp_noise_ff;
   logic signed [P2W-1:0]  r2;
   logic signed [LW:0]     res_m;
   logic [SW-1:0]          scaled;
   logic [15:0]            noise_in;

   always_comb begin
      r2     = (s8_p_ff + P2W'(1 << (F - 1))) >>> F;
      res_m  = (LW + 1)'(s8_l0_ff) + (LW + 1)'(r2) + (LW + 1)'(1 << F);
      if (res_m < 0) begin
         scaled = '0;
      end else begin
         scaled = ((SW'(res_m) << 15) + SW'(1 << (F - 1))) >> F;
      end
      if (scaled > SW'(16'hFFFF)) begin
         noise_in = 16'hFFFF;
      end else begin
         noise_in = scaled[15:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= s8_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      rsp_noise_ff <= noise_in;
   end

   assign rsp_strobe      = rsp_strobe_ff;
   assign rsp_noise_value = rsp_noise_ff;

   // ---------------------------------------------------------------
   // Checks.
   a_no_result_while_filling : assert property (@(posedge clock) disable iff (reset)
      busy |-> !rsp_strobe)
      else $error("result strobe during table fill");

   a_fill_done_stays_done : assert property (@(posedge clock) disable iff (reset)
      !busy |=> !busy)
      else $error("busy rose again without reset");

   a_eval_gives_result : assert property (@(posedge clock) disable iff (reset)
      (accept && req_operation == pn2d_pkg::OP_EVAL) |-> ##(pn2d_pkg::LATENCY) rsp_strobe)
      else $error("evaluate request lost its result");

   a_write_gives_none : assert property (@(posedge clock) disable iff (reset)
      (accept && req_operation == pn2d_pkg::OP_WRITE) |-> ##(pn2d_pkg::LATENCY) !rsp_strobe)
      else $error("table write produced a result");

endmodule
